[hw/rtl/scss_pkg.sv]
// Package for the serial command stepper sequencer.
// Holds command codes, register indexes, reset values, the result word type
// and the phase pattern lookup. No dependencies.
`default_nettype none

package scss_pkg;

  // Width of a received serial byte
  localparam int unsigned ByteW = 8;
  // Widths of the configuration registers
  localparam int unsigned StepsW = 10;
  localparam int unsigned PatternsW = 32;
  localparam int unsigned CfgDataW = 32;
  // Phase counter default width and product width (10b steps x 8b digit x 4)
  localparam int unsigned RemainingWidthDefault = 20;
  localparam int unsigned ProdW = StepsW + ByteW + 2;

  // Register reset values
  localparam logic [StepsW-1:0] StepsReset = 10'd520;
  localparam logic [PatternsW-1:0] PatternsReset = 32'h9030_60C0;

  // Command and digit byte codes
  localparam logic [ByteW-1:0] CmdForward = 8'h31;  // '1'
  localparam logic [ByteW-1:0] CmdReverse = 8'h32;  // '2'
  localparam logic [ByteW-1:0] CmdTurns = 8'h33;    // '3'
  localparam logic [ByteW-1:0] AsciiZero = 8'd48;

  // Input kinds
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_STEPS_PER_TURN = 1'b0,
    CFG_PHASE_PATTERNS = 1'b1
  } cfg_idx_e;

  // Command parser states
  typedef enum logic [2:0] {
    PARSE_IDLE  = 3'b001,
    PARSE_DIR   = 3'b010,
    PARSE_DIGIT = 3'b100
  } parse_e;

  // One result word
  typedef struct packed {
    logic [ByteW-1:0] port_value;
    logic             moving;
    logic             byte_dropped;
  } scss_result_t;

  // Select the port pattern of one phase
  function automatic logic [ByteW-1:0] phase_pattern(input logic [PatternsW-1:0] patterns,
                                                     input logic [1:0] idx);
    phase_pattern = patterns[idx*ByteW +: ByteW];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/scss_core.sv]
// Command parser and phase sequencer state of the stepper sequencer.
// Depends on scss_pkg; produces the next result word for each accepted word.
`default_nettype none

module scss_core import scss_pkg::*; #(
  parameter int unsigned REMAINING_WIDTH = RemainingWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_en_i,
  input  wire logic                 kind_i,
  input  wire logic [ByteW-1:0]     rx_byte_i,
  input  wire logic [StepsW-1:0]    steps_per_turn_i,
  input  wire logic [PatternsW-1:0] phase_patterns_i,
  output scss_result_t              result_o
);

  localparam int unsigned CntW = (REMAINING_WIDTH > ProdW) ? REMAINING_WIDTH : ProdW;
  localparam logic [CntW-1:0] CountLimit = CntW'({REMAINING_WIDTH{1'b1}});
  localparam logic [CntW-1:0] OneCycle = CntW'(4);

  parse_e                     parse_q, parse_d;
  logic [ByteW-1:0]           dir_q, dir_d;
  logic [1:0]                 idx_q, idx_d;
  logic                       rev_q, rev_d;
  logic [REMAINING_WIDTH-1:0] ticks_q, ticks_d;
  logic [ByteW-1:0]           port_q, port_d;
  logic                       dropped;

  logic                       start_en;
  logic                       start_rev;
  logic [CntW-1:0]            start_cnt;
  logic [CntW-1:0]            start_sat;
  logic [ByteW-1:0]           digit_val;
  logic [ProdW-1:0]           turns_prod;
  logic [1:0]                 start_idx;
  logic [1:0]                 step_idx;

  // Phase count for a turns command: steps * digit * 4
  assign digit_val = rx_byte_i - AsciiZero;
  assign turns_prod = {ProdW'(steps_per_turn_i) * ProdW'(digit_val)} << 2;
  assign start_sat = (start_cnt > CountLimit) ? CountLimit : start_cnt;
  assign start_idx = start_rev ? 2'd3 : 2'd0;
  assign step_idx = rev_q ? (idx_q - 2'd1) : (idx_q + 2'd1);

  // Next state for one word
  always_comb begin
    parse_d   = parse_q;
    dir_d     = dir_q;
    idx_d     = idx_q;
    rev_d     = rev_q;
    ticks_d   = ticks_q;
    port_d    = port_q;
    dropped   = 1'b0;
    start_en  = 1'b0;
    start_rev = 1'b0;
    start_cnt = OneCycle;

    if (kind_i == KIND_TICK) begin
      // Count down and advance the phase while still running
      if (ticks_q != '0) begin
        ticks_d = ticks_q - REMAINING_WIDTH'(1);
        if (ticks_q != REMAINING_WIDTH'(1)) begin
          idx_d  = step_idx;
          port_d = phase_pattern(phase_patterns_i, step_idx);
        end
      end
    end else if (ticks_q != '0) begin
      dropped = 1'b1;
    end else begin
      unique case (parse_q)
        PARSE_DIR: begin
          dir_d   = rx_byte_i;
          parse_d = PARSE_DIGIT;
        end
        PARSE_DIGIT: begin
          parse_d   = PARSE_IDLE;
          start_en  = (rx_byte_i >= AsciiZero) && (dir_q == CmdForward || dir_q == CmdReverse);
          start_rev = (dir_q == CmdReverse);
          start_cnt = CntW'(turns_prod);
        end
        default: begin
          parse_d = PARSE_IDLE;
          if (rx_byte_i == CmdForward) begin
            start_en = 1'b1;
          end else if (rx_byte_i == CmdReverse) begin
            start_en  = 1'b1;
            start_rev = 1'b1;
          end else if (rx_byte_i == CmdTurns) begin
            parse_d = PARSE_DIR;
          end
        end
      endcase

      // Launch a run on a nonzero phase count
      if (start_en && start_cnt != '0) begin
        rev_d   = start_rev;
        idx_d   = start_idx;
        ticks_d = REMAINING_WIDTH'(start_sat);
        port_d  = phase_pattern(phase_patterns_i, start_idx);
      end
    end
  end

  // Hold state between accepted words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= PARSE_IDLE;
      dir_q   <= '0;
      idx_q   <= '0;
      rev_q   <= 1'b0;
      ticks_q <= '0;
      port_q  <= '0;
    end else if (step_en_i) begin
      parse_q <= parse_d;
      dir_q   <= dir_d;
      idx_q   <= idx_d;
      rev_q   <= rev_d;
      ticks_q <= ticks_d;
      port_q  <= port_d;
    end
  end

  assign result_o.port_value   = port_d;
  assign result_o.moving       = (ticks_d != '0);
  assign result_o.byte_dropped = dropped;

endmodule

`default_nettype wire

[hw/rtl/serial_command_stepper_sequencer_unit.sv]
// Top level of the serial command stepper sequencer: handshake, config
// registers and the output register. Depends on scss_pkg and scss_core.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------
//   in       | into      | in_valid_i/in_stall_o| kind_i, rx_byte_i
//   out      | out of    | out_valid_o/out_stall_i | port_value_o, moving_o, byte_dropped_o
//   cfg      | into      | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle while in_stall_o is low; its result appears in the
// output register on the next cycle, set by the single parser/sequencer stage in scss_core.
// The input stalls only while the output register is full and stalled.
// Reset clears the parser, the run and the port pattern and loads register
// defaults; no clearing pass is needed.
`default_nettype none

module serial_command_stepper_sequencer_unit import scss_pkg::*; #(
  parameter int unsigned REMAINING_WIDTH = RemainingWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                kind_i,
  input  wire logic [ByteW-1:0]    rx_byte_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [ByteW-1:0]    port_value_o,
  output      logic                moving_o,
  output      logic                byte_dropped_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [StepsW-1:0]    steps_q;
  logic [PatternsW-1:0] patterns_q;
  logic                 in_accept;
  logic                 out_valid_q;
  scss_result_t         res_d;
  scss_result_t         res_q;

  // Accept unless a finished word is waiting on a stalled output
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q    <= StepsReset;
      patterns_q <= PatternsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEPS_PER_TURN: steps_q    <= cfg_data_i[StepsW-1:0];
        CFG_PHASE_PATTERNS: patterns_q <= cfg_data_i[PatternsW-1:0];
        default:            steps_q    <= steps_q;
      endcase
    end
  end

  scss_core #(
    .REMAINING_WIDTH(REMAINING_WIDTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (in_accept),
    .kind_i          (kind_i),
    .rx_byte_i       (rx_byte_i),
    .steps_per_turn_i(steps_q),
    .phase_patterns_i(patterns_q),
    .result_o        (res_d)
  );

  // Track output word occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the output word on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign port_value_o   = res_q.port_value;
  assign moving_o       = res_q.moving;
  assign byte_dropped_o = res_q.byte_dropped;

endmodule

`default_nettype wire

[hw/rtl/scss_checker.sv]
// Port-level checks for the serial command stepper sequencer top level.
// Depends on scss_pkg; bound to serial_command_stepper_sequencer_unit below.
`default_nettype none

module scss_checker import scss_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [ByteW-1:0] port_value_o,
  input wire logic             moving_o,
  input wire logic             byte_dropped_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(port_value_o) && $stable(moving_o) && $stable(byte_dropped_o))
    else $error("stalled output word changed");

  // Input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Every accepted word yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // A dropped byte only happens during a run
  a_drop_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_dropped_o |-> moving_o)
    else $error("byte dropped while idle");

endmodule

bind serial_command_stepper_sequencer_unit scss_checker u_scss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .port_value_o  (port_value_o),
  .moving_o      (moving_o),
  .byte_dropped_o(byte_dropped_o)
);

`default_nettype wire
